// ----- rtl/core/bdq_pkg.sv -----
// Shared types and constants for the bounded deque with positional delete.
package bdq_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int DATA_W        = 32;
   localparam int POS_W         = 8;
   localparam int IDX_W         = 5;

   typedef enum logic [1:0] {
      REQ_INS_FRONT = 2'd0,
      REQ_INS_BACK  = 2'd1,
      REQ_DELETE    = 2'd2,
      REQ_READ_ALL  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_HOLD      = 3'd0,
      OP_INS_FRONT = 3'd1,
      OP_INS_BACK  = 3'd2,
      OP_DELETE    = 3'd3,
      OP_ROTATE    = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [DATA_W-1:0]  value;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

endpackage

// ----- rtl/core/bdq_if.sv -----
// Valid/ready channel interfaces for requests and responses.
interface bdq_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          req_type;
   logic signed [bdq_pkg::DATA_W-1:0]   value;
   logic [bdq_pkg::POS_W-1:0]           position;

   modport source (output valid, req_type, value, position, input ready);
   modport sink   (input valid, req_type, value, position, output ready);
endinterface

interface bdq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic signed [bdq_pkg::DATA_W-1:0]   data;
   logic [bdq_pkg::IDX_W-1:0]           entry_index;
   logic                                last;

   modport source (output valid, status, data, entry_index, last, input ready);
   modport sink   (input valid, status, data, entry_index, last, output ready);
endinterface

// ----- rtl/core/bounded_deque_positional_delete_unit.sv -----
// Top level: bounded deque of signed words with insert, positional delete and read-out.
//
//   channel  | dir | handshake              | beat payload
//   req_bus  | in  | valid/ready            | req_type, value, position
//   rsp_bus  | out | valid/ready            | status, data, entry_index, last
//
// Insert and delete issue one beat; the cell chain shifts in place unless full or empty.
// Read-out issues one beat per stored entry, one per cycle if not stalled; the chain
// rotates by one word each beat so cell 0 always holds the next word; the list ends whole.
// A new request is taken only when idle and the response register is free or draining.
// Reset is synchronous: length goes to zero; cell contents are left as they are.
// A stalled response holds the block; nothing is lost or repeated.
module bounded_deque_positional_delete_unit #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   bdq_req_if.sink   req_bus,
   bdq_rsp_if.source rsp_bus
);
   localparam int LW = $clog2(DEPTH + 1);
   localparam int PW = $clog2(DEPTH);
   localparam int DW = bdq_pkg::DATA_W;
   localparam int XW = bdq_pkg::IDX_W;

   bdq_pkg::state_type    state_ff, state_in;
   logic [LW-1:0]         length_ff, length_in;
   logic [PW-1:0]         cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic signed [DW-1:0]  rsp_data_ff, rsp_data_in;
   logic [XW-1:0]         rsp_idx_ff, rsp_idx_in;
   logic                  rsp_last_ff, rsp_last_in;

   bdq_pkg::cell_cmd_type cmd;
   logic [PW-1:0]         place;
   logic signed [DW-1:0]  cell_q     [DEPTH];
   logic signed [DW-1:0]  left_bus   [DEPTH];
   logic signed [DW-1:0]  right_bus  [DEPTH];
   logic signed [DW-1:0]  removed;
   logic                  out_free;
   logic                  accept;
   logic                  full;
   logic                  pos_tail;
   logic                  read_last;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == bdq_pkg::S_IDLE) && out_free;
   assign accept        = req_bus.valid && req_bus.ready;
   assign full          = (length_ff == LW'(DEPTH));
   assign pos_tail      = (req_bus.position == '0) ||
                          (9'(req_bus.position) > 9'(length_ff));
   assign place         = pos_tail ? PW'(length_ff - LW'(1))
                                   : PW'(req_bus.position - 8'd1);
   assign read_last     = (LW'(cnt_ff) == length_ff - LW'(1));

   // neighbor wiring of the chain
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         left_bus[i]  = (i == 0) ? cmd.value : cell_q[(i == 0) ? 0 : i - 1];
         right_bus[i] = (i == DEPTH - 1) ? cell_q[i] : cell_q[(i == DEPTH - 1) ? i : i + 1];
      end
   end

   // AND-OR select of the word being removed
   always_comb begin
      removed = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (place == PW'(i)) removed = removed | cell_q[i];
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      bdq_cell #(.DEPTH(DEPTH), .IDX(g)) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .length     (length_ff),
         .place      (place),
         .left_data  (left_bus[g]),
         .right_data (right_bus[g]),
         .wrap_data  (cell_q[0]),
         .data       (cell_q[g])
      );
   end

   always_comb begin
      state_in      = state_ff;
      length_in     = length_ff;
      cnt_in        = cnt_ff;
      cmd.op        = bdq_pkg::OP_HOLD;
      cmd.value     = req_bus.value;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         bdq_pkg::S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_status_in = bdq_pkg::ST_DONE;
               rsp_data_in   = req_bus.value;
               rsp_idx_in    = '0;
               case (bdq_pkg::req_kind_type'(req_bus.req_type))
                  bdq_pkg::REQ_INS_FRONT, bdq_pkg::REQ_INS_BACK: begin
                     if (full) begin
                        rsp_status_in = bdq_pkg::ST_FULL;
                     end else begin
                        length_in = length_ff + LW'(1);
                        if (req_bus.req_type == bdq_pkg::REQ_INS_FRONT) begin
                           cmd.op = bdq_pkg::OP_INS_FRONT;
                        end else begin
                           cmd.op     = bdq_pkg::OP_INS_BACK;
                           rsp_idx_in = XW'(length_ff);
                        end
                     end
                  end
                  bdq_pkg::REQ_DELETE: begin
                     if (length_ff == '0) begin
                        rsp_status_in = bdq_pkg::ST_EMPTY;
                        rsp_data_in   = '0;
                     end else begin
                        cmd.op      = bdq_pkg::OP_DELETE;
                        length_in   = length_ff - LW'(1);
                        rsp_data_in = removed;
                        rsp_idx_in  = XW'(place);
                     end
                  end
                  bdq_pkg::REQ_READ_ALL: begin
                     if (length_ff == '0) begin
                        rsp_status_in = bdq_pkg::ST_EMPTY;
                        rsp_data_in   = '0;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
                        cnt_in       = '0;
                        state_in     = bdq_pkg::S_READ;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         bdq_pkg::S_READ: begin
            if (out_free) begin
               cmd.op        = bdq_pkg::OP_ROTATE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = bdq_pkg::ST_DONE;
               rsp_data_in   = cell_q[0];
               rsp_idx_in    = XW'(cnt_ff);
               rsp_last_in   = read_last;
               cnt_in        = cnt_ff + PW'(1);
               if (read_last) state_in = bdq_pkg::S_IDLE;
            end
         end
         default: state_in = bdq_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdq_pkg::S_IDLE;
         length_ff    <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.data        = rsp_data_ff;
   assign rsp_bus.entry_index = rsp_idx_ff;
   assign rsp_bus.last        = rsp_last_ff;
endmodule

// ----- rtl/core/bdq_cell.sv -----
// One storage cell of the deque chain; picks its next word from its neighbors.
module bdq_cell #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
   parameter int IDX   = 0,
   localparam int LW   = $clog2(DEPTH + 1),
   localparam int PW   = $clog2(DEPTH)
) (
   input  logic                               clock,
   input  bdq_pkg::cell_cmd_type              cmd,
   input  logic [LW-1:0]                      length,
   input  logic [PW-1:0]                      place,
   input  logic signed [bdq_pkg::DATA_W-1:0]  left_data,
   input  logic signed [bdq_pkg::DATA_W-1:0]  right_data,
   input  logic signed [bdq_pkg::DATA_W-1:0]  wrap_data,
   output logic signed [bdq_pkg::DATA_W-1:0]  data
);
   localparam logic [LW-1:0] MY_L = LW'(IDX);
   localparam logic [PW-1:0] MY_P = PW'(IDX);

   logic signed [bdq_pkg::DATA_W-1:0] data_ff;
   logic signed [bdq_pkg::DATA_W-1:0] data_in;
   logic [LW-1:0]                     tail;

   assign tail = length - LW'(1);

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         bdq_pkg::OP_INS_FRONT: data_in = left_data;
         bdq_pkg::OP_INS_BACK: begin
            if (length == MY_L) data_in = cmd.value;
         end
         bdq_pkg::OP_DELETE: begin
            if (MY_P >= place) data_in = right_data;
         end
         bdq_pkg::OP_ROTATE: begin
            // front word wraps around to the tail slot
            if (MY_L < tail) data_in = right_data;
            else if (MY_L == tail) data_in = wrap_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
endmodule

// ----- rtl/core/bdq_checker.sv -----
// Port-level checks for the deque unit, bound to the top level.
module bdq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [1:0]                         rsp_status,
   input logic signed [bdq_pkg::DATA_W-1:0]  rsp_data,
   input logic [bdq_pkg::IDX_W-1:0]          rsp_entry_index,
   input logic                               rsp_last
);
   // a stalled beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_last))
      else $error("response changed while stalled");

   // no new request while a read-out is still streaming
   a_no_req_mid_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !(req_valid && req_ready))
      else $error("request accepted during read-out");

   a_mid_burst_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == bdq_pkg::ST_DONE)
      else $error("non-final beat with error status");

   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bdq_pkg::ST_EMPTY |->
         rsp_last && rsp_data == '0 && rsp_entry_index == '0)
      else $error("malformed empty response");

   a_full_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bdq_pkg::ST_FULL |-> rsp_last && rsp_entry_index == '0)
      else $error("malformed full response");
endmodule

bind bounded_deque_positional_delete_unit bdq_checker u_bdq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_data        (rsp_bus.data),
   .rsp_entry_index (rsp_bus.entry_index),
   .rsp_last        (rsp_bus.last)
);

// ----- tb/sv/tb_bounded_deque_positional_delete_unit.sv -----
// Self-checking testbench for the bounded deque with positional delete.
module tb_bounded_deque_positional_delete_unit;

   localparam int DEPTH      = bdq_pkg::DEPTH_DEFAULT;
   localparam int DATA_W     = bdq_pkg::DATA_W;
   localparam int POS_W      = bdq_pkg::POS_W;
   localparam int IDX_W      = bdq_pkg::IDX_W;
   localparam int ITEMS      = 370;
   localparam int MAX_GAP    = 16;
   localparam int HOLD_LEN   = 200;
   localparam int IDLE_LIMIT = 3000;
   localparam int TAIL_WAIT  = 20;

   typedef struct {
      bdq_pkg::req_kind_type    kind;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
      int unsigned              gap;
      bit                       drain_first;
   } deque_req_type;

   typedef struct {
      bdq_pkg::status_type      status;
      logic signed [DATA_W-1:0] data;
      logic [IDX_W-1:0]         entry_index;
      logic                     last;
   } deque_rsp_type;

   logic clock;
   logic reset;

   bdq_req_if req_bus ();
   bdq_rsp_if rsp_bus ();

   bounded_deque_positional_delete_unit #(.DEPTH(DEPTH)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   deque_req_type            req_pending[$];
   deque_rsp_type            rsp_expect[$];
   logic signed [DATA_W-1:0] list_model[$];

   int errors;
   int gen_len;
   int tx_gap;
   int rx_stall;
   int rx_hold;
   int rsp_beats;
   int idle_cycles;
   int kind_seen[4];
   int full_rejects;
   int empty_hits;
   int max_fill;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // ---------------------------------------------------------------- prediction
   function automatic void push_rsp(bdq_pkg::status_type st, logic signed [DATA_W-1:0] d,
                                    int idx, logic lst);
      deque_rsp_type r;
      r.status      = st;
      r.data        = d;
      r.entry_index = idx[IDX_W-1:0];
      r.last        = lst;
      rsp_expect.push_back(r);
   endfunction

   function automatic void apply_request(bdq_pkg::req_kind_type kind,
                                         logic signed [DATA_W-1:0] val,
                                         logic [POS_W-1:0] pos);
      int place;
      logic signed [DATA_W-1:0] removed;
      kind_seen[kind]++;
      case (kind)
         bdq_pkg::REQ_INS_FRONT, bdq_pkg::REQ_INS_BACK: begin
            if (list_model.size() >= DEPTH) begin
               full_rejects++;
               push_rsp(bdq_pkg::ST_FULL, val, 0, 1'b1);
            end else if (kind == bdq_pkg::REQ_INS_FRONT) begin
               list_model.push_front(val);
               push_rsp(bdq_pkg::ST_DONE, val, 0, 1'b1);
            end else begin
               list_model.push_back(val);
               push_rsp(bdq_pkg::ST_DONE, val, list_model.size() - 1, 1'b1);
            end
         end
         bdq_pkg::REQ_DELETE: begin
            if (list_model.size() == 0) begin
               empty_hits++;
               push_rsp(bdq_pkg::ST_EMPTY, '0, 0, 1'b1);
            end else begin
               // position 0 or past the end removes the tail
               if (pos == 0 || pos > list_model.size())
                  place = list_model.size() - 1;
               else
                  place = pos - 1;
               removed = list_model[place];
               list_model.delete(place);
               push_rsp(bdq_pkg::ST_DONE, removed, place, 1'b1);
            end
         end
         default: begin
            if (list_model.size() == 0) begin
               empty_hits++;
               push_rsp(bdq_pkg::ST_EMPTY, '0, 0, 1'b1);
            end else begin
               for (int i = 0; i < list_model.size(); i++)
                  push_rsp(bdq_pkg::ST_DONE, list_model[i], i, i == list_model.size() - 1);
            end
         end
      endcase
      if (list_model.size() > max_fill) max_fill = list_model.size();
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic void add_item(bdq_pkg::req_kind_type kind,
                                    logic signed [DATA_W-1:0] val,
                                    logic [POS_W-1:0] pos, bit drain_first);
      deque_req_type it;
      it.kind        = kind;
      it.value       = val;
      it.position    = pos;
      it.drain_first = drain_first;
      // every third block of 50 items goes back to back
      it.gap         = ((req_pending.size() / 50) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
      req_pending.push_back(it);
      if (kind == bdq_pkg::REQ_INS_FRONT || kind == bdq_pkg::REQ_INS_BACK) begin
         if (gen_len < DEPTH) gen_len++;
      end else if (kind == bdq_pkg::REQ_DELETE && gen_len > 0) begin
         gen_len--;
      end
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position(int len);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 8'hFF;
         2:       return POS_W'($urandom_range(0, 255));
         3:       return (len < 255) ? POS_W'(len + 1) : 8'hFF;
         default: return (len == 0) ? '0 : POS_W'($urandom_range(1, len));
      endcase
   endfunction

   function automatic bdq_pkg::req_kind_type pick_ins();
      return $urandom_range(0, 1) ? bdq_pkg::REQ_INS_BACK : bdq_pkg::REQ_INS_FRONT;
   endfunction

   function automatic void build_stimulus();
      int episode;
      int r;
      bit sync;
      // directed: empty cases, extremes, every delete placement, single-entry delete
      add_item(bdq_pkg::REQ_READ_ALL,  '0, 8'd0, 1'b0);
      add_item(bdq_pkg::REQ_DELETE,    '0, 8'd5, 1'b0);
      add_item(bdq_pkg::REQ_INS_FRONT, 32'sh7FFF_FFFF, 8'd0, 1'b0);
      add_item(bdq_pkg::REQ_DELETE,    '0, 8'd1, 1'b0);
      add_item(bdq_pkg::REQ_INS_BACK,  32'sh8000_0000, 8'hFF, 1'b0);
      add_item(bdq_pkg::REQ_INS_FRONT, -32'sd1, 8'hFF, 1'b0);
      add_item(bdq_pkg::REQ_INS_BACK,  '0, 8'd0, 1'b0);
      add_item(bdq_pkg::REQ_INS_FRONT, 32'sh5555_5555, 8'hAA, 1'b0);
      add_item(bdq_pkg::REQ_INS_BACK,  32'shAAAA_AAAA, 8'h55, 1'b0);
      add_item(bdq_pkg::REQ_READ_ALL,  32'sh1234_5678, 8'd7, 1'b0);
      add_item(bdq_pkg::REQ_DELETE,    '0, 8'd0, 1'b0);
      add_item(bdq_pkg::REQ_DELETE,    '0, 8'hFF, 1'b0);
      add_item(bdq_pkg::REQ_DELETE,    '0, 8'd2, 1'b0);
      add_item(bdq_pkg::REQ_DELETE,    '0, 8'd3, 1'b0);
      add_item(bdq_pkg::REQ_DELETE,    '0, 8'd4, 1'b0);
      add_item(bdq_pkg::REQ_READ_ALL,  '0, 8'd0, 1'b1);
      add_item(bdq_pkg::REQ_DELETE,    -32'sd1, 8'd1, 1'b0);
      add_item(bdq_pkg::REQ_DELETE,    '0, 8'd0, 1'b0);
      add_item(bdq_pkg::REQ_READ_ALL,  '0, 8'd0, 1'b0);

      // random episodes: fill to full, drain to empty, or mixed traffic
      episode = 0;
      while (req_pending.size() < ITEMS) begin
         r = (episode == 0) ? 0 : $urandom_range(0, 3);
         sync = (episode % 5 == 3);
         case (r)
            0: begin
               while (gen_len < DEPTH)
                  add_item(pick_ins(), pick_value(), POS_W'($urandom), 1'b0);
               repeat ($urandom_range(1, 3))
                  add_item(pick_ins(), pick_value(), POS_W'($urandom), 1'b0);
               add_item(bdq_pkg::REQ_READ_ALL, $urandom, POS_W'($urandom), 1'b0);
            end
            1: begin
               while (gen_len > 0)
                  add_item(bdq_pkg::REQ_DELETE, $urandom, pick_position(gen_len), 1'b0);
               add_item(bdq_pkg::REQ_DELETE, $urandom, pick_position(0), 1'b0);
               add_item(bdq_pkg::REQ_READ_ALL, $urandom, POS_W'($urandom), 1'b0);
            end
            default: begin
               repeat (24) begin
                  case ($urandom_range(0, 19))
                     0, 1, 2, 3, 4, 5, 6, 7, 8:
                        add_item(pick_ins(), pick_value(), POS_W'($urandom), 1'b0);
                     9, 10, 11, 12, 13, 14, 15, 16, 17:
                        add_item(bdq_pkg::REQ_DELETE, $urandom, pick_position(gen_len), 1'b0);
                     default:
                        add_item(bdq_pkg::REQ_READ_ALL, $urandom, POS_W'($urandom), 1'b0);
                  endcase
               end
            end
         endcase
         // now and then the sender waits for every outstanding beat first
         if (sync) add_item(bdq_pkg::REQ_READ_ALL, $urandom, POS_W'($urandom), 1'b1);
         episode++;
      end
   endfunction

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      deque_req_type it;
      logic offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
         tx_gap = 0;
      end else begin
         offer = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            apply_request(bdq_pkg::req_kind_type'(req_bus.req_type), req_bus.value,
                          req_bus.position);
            offer  = 1'b0;
            tx_gap = (req_pending.size() > 0) ? req_pending[0].gap : 0;
         end
         if (!offer) begin
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (req_pending.size() > 0 &&
                         !(req_pending[0].drain_first && rsp_expect.size() > 0)) begin
               it = req_pending.pop_front();
               req_bus.req_type <= it.kind;
               req_bus.value    <= it.value;
               req_bus.position <= it.position;
               offer = 1'b1;
            end
         end
         req_bus.valid <= offer;
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      deque_rsp_type exp;
      bit accepted;
      int wait_cycles;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_stall = 0;
         rx_hold  = 0;
      end else begin
         accepted = rsp_bus.valid && rsp_bus.ready;
         if (accepted) begin
            rsp_beats++;
            if (rsp_expect.size() == 0) begin
               $error("unexpected beat: status %0d data %0d index %0d last %0b",
                      rsp_bus.status, rsp_bus.data, rsp_bus.entry_index, rsp_bus.last);
               errors++;
            end else begin
               exp = rsp_expect.pop_front();
               if (rsp_bus.status !== exp.status) begin
                  $error("status: expected %0d, got %0d", exp.status, rsp_bus.status);
                  errors++;
               end
               if (rsp_bus.data !== exp.data) begin
                  $error("data: expected %0d, got %0d", exp.data, rsp_bus.data);
                  errors++;
               end
               if (rsp_bus.entry_index !== exp.entry_index) begin
                  $error("entry_index: expected %0d, got %0d",
                         exp.entry_index, rsp_bus.entry_index);
                  errors++;
               end
               if (rsp_bus.last !== exp.last) begin
                  $error("last: expected %0b, got %0b", exp.last, rsp_bus.last);
                  errors++;
               end
            end
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_bus.ready <= 1'b0;
         end else if (accepted && (rsp_beats == 60 || rsp_beats == 350)) begin
            // long back-pressure: the request side must stall behind it
            rx_hold = HOLD_LEN;
            rsp_bus.ready <= 1'b0;
         end else if (accepted) begin
            wait_cycles = ((rsp_beats / 80) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
            rx_stall = wait_cycles;
            rsp_bus.ready <= (wait_cycles == 0);
         end else if (rx_stall > 1) begin
            rx_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rx_stall = 0;
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d beats still owed",
                     idle_cycles, rsp_expect.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      errors       = 0;
      gen_len      = 0;
      rsp_beats    = 0;
      idle_cycles  = 0;
      full_rejects = 0;
      empty_hits   = 0;
      max_fill     = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = bdq_pkg::REQ_INS_FRONT;
      req_bus.value    = '0;
      req_bus.position = '0;
      rsp_bus.ready    = 1'b0;
      build_stimulus();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // sample away from the active edge so driver updates are settled
      @(negedge clock);
      while (req_pending.size() > 0 || req_bus.valid || rsp_expect.size() > 0)
         @(negedge clock);
      repeat (TAIL_WAIT) @(negedge clock);

      $display("Ran %0d requests: %0d front, %0d back inserts, %0d deletes, %0d read-outs.",
               kind_seen[bdq_pkg::REQ_INS_FRONT] + kind_seen[bdq_pkg::REQ_INS_BACK] +
               kind_seen[bdq_pkg::REQ_DELETE] + kind_seen[bdq_pkg::REQ_READ_ALL],
               kind_seen[bdq_pkg::REQ_INS_FRONT], kind_seen[bdq_pkg::REQ_INS_BACK],
               kind_seen[bdq_pkg::REQ_DELETE], kind_seen[bdq_pkg::REQ_READ_ALL]);
      $display("Checked %0d beats; %0d full rejects, %0d empty-list hits, peak fill %0d.",
               rsp_beats, full_rejects, empty_hits, max_fill);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
